// ===== hdl/shpc_pkg.sv =====
// Package: widths, item types and controller-to-datapath command for the history check
package shpc_pkg;

    // History size and derived widths
    localparam int HISTORY_DEPTH = 8;
    localparam int VAL_W         = 11;
    localparam int CHG_W         = 10;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W         = $clog2((HISTORY_DEPTH - 1) * ((1 << VAL_W) - 1) + 1);
    localparam int STEP_W        = $clog2(SUM_W);

    // Fixed values
    localparam logic [VAL_W-1:0] SOC_LIMIT    = VAL_W'(1000);
    localparam logic [CHG_W-1:0] CHANGE_RESET = CHG_W'(50);

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic             plausible;
        logic [VAL_W-1:0] max_step;
        logic [VAL_W-1:0] mean_step;
        logic [CNT_W-1:0] fill_count;
    } t_out_item;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             accept;
        logic [PTR_W-1:0] rd_addr;
        logic             chk_en;
        logic             st_en;
        logic             st_first;
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic             div_load;
        logic             div_step;
        logic             load_out;
        logic [CNT_W-1:0] divisor;
        logic [CNT_W-1:0] fill_count;
    } t_dp_cmd;

    function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hdl/shpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module shpc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/shpc_datapath.sv =====
// Datapath: history RAM, jump check, neighbor statistics, divider and result register
module shpc_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  shpc_pkg::t_in_item      i_in,
    input  logic                    i_cfg_we,
    input  logic [shpc_pkg::CHG_W-1:0] i_cfg_wdata,
    input  shpc_pkg::t_dp_cmd       i_cmd,
    output shpc_pkg::t_out_item     o_out
);
    import shpc_pkg::*;

    logic [CHG_W-1:0] r_max_change;
    logic [VAL_W-1:0] r_sample;
    logic             r_ok;
    logic [VAL_W-1:0] r_prev;
    logic [VAL_W-1:0] r_max;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    t_out_item        r_out;

    logic [VAL_W-1:0] rdata;
    logic [VAL_W-1:0] chk_diff;
    logic [VAL_W-1:0] nb_diff;
    logic [CNT_W:0]   div_trial;
    logic [CNT_W:0]   div_sub;
    logic             div_ge;

    // History store
    shpc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (i_cmd.waddr),
        .i_wdata (r_sample),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rdata)
    );

    // Compare against the new sample and against the previous neighbor
    assign chk_diff  = abs_diff(r_sample, rdata);
    assign nb_diff   = abs_diff(rdata, r_prev);

    // One restoring division step
    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, i_cmd.divisor});
    assign div_sub   = div_trial - {1'b0, i_cmd.divisor};

    // Hold the change limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_change <= CHANGE_RESET;
        end else if (i_cfg_we) begin
            r_max_change <= i_cfg_wdata;
        end
    end

    // Capture the item, judge it, gather statistics and divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_in.sample_value;
            r_ok     <= (i_in.kind == KIND_CLEAR) || (i_in.sample_value <= SOC_LIMIT);
            r_max    <= '0;
            r_sum    <= '0;
            r_quo    <= '0;
        end else begin
            if (i_cmd.chk_en && (chk_diff > {1'b0, r_max_change})) begin
                r_ok <= 1'b0;
            end
            if (i_cmd.st_en) begin
                r_prev <= rdata;
                if (!i_cmd.st_first) begin
                    if (nb_diff > r_max) begin
                        r_max <= nb_diff;
                    end
                    r_sum <= r_sum + SUM_W'(nb_diff);
                end
            end
            if (i_cmd.div_load) begin
                r_rem <= '0;
                r_quo <= r_sum;
            end else if (i_cmd.div_step) begin
                r_rem <= div_ge ? div_sub[CNT_W-1:0] : div_trial[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], div_ge};
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.plausible  <= r_ok;
            r_out.max_step   <= r_max;
            r_out.mean_step  <= r_quo[VAL_W-1:0];
            r_out.fill_count <= i_cmd.fill_count;
        end
    end

    assign o_out = r_out;

endmodule

// ===== hdl/shpc_ctrl.sv =====
// Controller: sequences judge, write or fill, statistics walk, divide and result hand-off
module shpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output shpc_pkg::t_dp_cmd o_cmd
);
    import shpc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_JUDGE = 7'b0000010,
        S_WRITE = 7'b0000100,
        S_FILL  = 7'b0001000,
        S_STATS = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_first, n_first;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    logic              issue;
    logic              out_free;

    assign issue    = (r_idx < r_count);
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_pend         = r_pend;
        n_first        = r_first;
        n_wp           = r_wp;
        n_count        = r_count;
        n_step         = r_step;
        n_out_valid    = r_out_valid && i_out_stall;
        o_cmd          = '0;
        o_cmd.rd_addr  = r_idx[PTR_W-1:0];
        o_cmd.waddr    = r_wp;
        o_cmd.st_first = r_first;
        o_cmd.divisor  = r_count - 1'b1;
        o_cmd.fill_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_state      = (i_in_kind == KIND_CLEAR) ? S_FILL : S_JUDGE;
                end
            end
            S_JUDGE: begin
                // walk valid entries, read data returns in the following cycle
                o_cmd.chk_en = r_pend;
                n_pend       = issue;
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.we = 1'b1;
                n_wp     = (r_wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_count < CNT_W'(HISTORY_DEPTH)) begin
                    n_count = r_count + 1'b1;
                end
                n_idx   = '0;
                n_pend  = 1'b0;
                n_state = S_STATS;
            end
            S_FILL: begin
                // sweep every entry with the fill value
                o_cmd.we    = 1'b1;
                o_cmd.waddr = r_idx[PTR_W-1:0];
                if (r_idx == CNT_W'(HISTORY_DEPTH - 1)) begin
                    n_wp    = '0;
                    n_count = CNT_W'(HISTORY_DEPTH);
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_STATS;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_STATS: begin
                o_cmd.st_en = r_pend;
                n_pend      = issue;
                n_first     = (r_idx == '0);
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end else if (!r_pend) begin
                    if (r_count < CNT_W'(2)) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.div_load = 1'b1;
                        n_step         = '0;
                        n_state        = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hand off once the result register is free
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_wp        <= '0;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_first     <= n_first;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/sample_history_plausibility_check.sv =====
// Top level: state-of-charge sample plausibility check over a ring history
//
//   channel  direction  handshake                payload
//   in       input      i_in_valid / o_in_stall  i_in  (kind, sample_value)
//   out      output     o_out_valid / i_out_stall o_out (plausible, max_step,
//                                                        mean_step, fill_count)
//   cfg      input      i_cfg_we                 i_cfg_wdata (max_change)
//
// One item at a time. A sample item walks its n stored entries to judge it, is
// written, walks the n' entries after the write for statistics and divides; a sample
// into an empty history skips the divide; a clear item fills every entry first. The
// time is set by the single read port of the history RAM, walked once to judge and
// once for statistics, and by the one-bit-per-cycle divider (14 steps).
// Reset clears pointer, count and result valid; the history RAM is not cleared.
// A result waits in the output register while the next item is taken and worked on;
// only its final hand-off waits for the output side to stop stalling.
module sample_history_plausibility_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  shpc_pkg::t_in_item         i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output shpc_pkg::t_out_item        o_out,
    input  logic                       i_cfg_we,
    input  logic [shpc_pkg::CHG_W-1:0] i_cfg_wdata
);
    import shpc_pkg::*;

    t_dp_cmd cmd;

    // Sequencer
    shpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in.kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // History, arithmetic and result register
    shpc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/shpc_checker.sv =====
// Checker: port-level properties of the plausibility check, bound to the top level
module shpc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input shpc_pkg::t_out_item        o_out
);
    import shpc_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An accepted item keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // Fewer than two entries give zero statistics
    a_small_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.fill_count < CNT_W'(2))
        |-> (o_out.max_step == '0) && (o_out.mean_step == '0))
        else $error("statistics nonzero with fewer than two entries");

    // Mean never exceeds the largest step, count never exceeds depth
    a_mean_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.mean_step <= o_out.max_step)
        && (o_out.fill_count <= CNT_W'(HISTORY_DEPTH)))
        else $error("result statistics out of bounds");

endmodule

bind sample_history_plausibility_check shpc_checker u_shpc_checker (.*);

// ===== bench/sample_history_plausibility_check_tb.sv =====
// Self-checking bench for the state-of-charge history plausibility check
`timescale 1ns / 100ps

module sample_history_plausibility_check_tb;
    import shpc_pkg::*;

    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 250;
    localparam int QUIET_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 60;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int SOC_MAX       = 1000;
    localparam int MAX_PRINTED   = 100;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_CLEAR, ROW_CFG} t_row_op;

    // One line of the directed table
    typedef struct {
        t_row_op   op;
        int        value;
        bit        has_want;
        t_out_item want;
    } t_row;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_item           in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_item;
    logic               cfg_we    = 1'b0;
    logic [CHG_W-1:0]   cfg_wdata = '0;

    // Predictor state: history ring, pointer, fill level and limit
    logic [VAL_W-1:0]   hist_model [HISTORY_DEPTH];
    int                 hist_wr_ptr      = 0;
    int                 hist_fill        = 0;
    int                 model_max_change = int'(CHANGE_RESET);

    t_out_item          verdict_queue [$];

    int                 error_count   = 0;
    int                 item_count    = 0;
    int                 result_count  = 0;
    int                 clear_count   = 0;
    int                 flagged_count = 0;
    bit                 quiet_tail    = 1'b0;
    int                 in_gap_pct    = 30;
    int                 out_stall_pct = 35;

    sample_history_plausibility_check u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int distance(input int a, input int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Judge a sample against the history, update the ring, return the statistics
    function automatic t_out_item judge_and_record(input t_in_item item);
        t_out_item res;
        int        v;
        int        largest;
        int        total;
        int        d;
        v             = int'(item.sample_value);
        res.plausible = 1'b1;
        if (item.kind == KIND_SAMPLE) begin
            // range first; an out-of-range sample skips the jump check
            if (v > SOC_MAX) begin
                res.plausible = 1'b0;
            end else begin
                for (int k = 0; k < hist_fill; k++) begin
                    if (distance(v, int'(hist_model[k])) > model_max_change) begin
                        res.plausible = 1'b0;
                    end
                end
            end
            hist_model[hist_wr_ptr] = item.sample_value;
            hist_wr_ptr             = (hist_wr_ptr + 1) % HISTORY_DEPTH;
            if (hist_fill < HISTORY_DEPTH) begin
                hist_fill++;
            end
        end else begin
            // clear fills the whole ring unchecked
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                hist_model[k] = item.sample_value;
            end
            hist_wr_ptr = 0;
            hist_fill   = HISTORY_DEPTH;
        end
        // neighbour steps in storage order
        largest = 0;
        total   = 0;
        for (int k = 1; k < hist_fill; k++) begin
            d = distance(int'(hist_model[k]), int'(hist_model[k-1]));
            if (d > largest) begin
                largest = d;
            end
            total += d;
        end
        res.max_step   = VAL_W'(largest);
        res.mean_step  = (hist_fill < 2) ? '0 : VAL_W'(total / (hist_fill - 1));
        res.fill_count = CNT_W'(hist_fill);
        return res;
    endfunction

    function automatic t_row dir_row(input t_row_op op, input int value,
                                     input int want_ok = -1, input int want_max = 0,
                                     input int want_mean = 0, input int want_fill = 0);
        t_row r;
        r.op                = op;
        r.value             = value;
        r.has_want          = (want_ok >= 0);
        r.want.plausible    = 1'(want_ok);
        r.want.max_step     = VAL_W'(want_max);
        r.want.mean_step    = VAL_W'(want_mean);
        r.want.fill_count   = CNT_W'(want_fill);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Compare one result with the oldest pending verdict
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (verdict_queue.size() == 0) begin
            report_mismatch("result with no pending item", 1, 0);
            return;
        end
        want = verdict_queue.pop_front();
        result_count++;
        if (got.plausible !== want.plausible) begin
            report_mismatch("plausible", int'(got.plausible), int'(want.plausible));
        end
        if (got.max_step !== want.max_step) begin
            report_mismatch("max_step", int'(got.max_step), int'(want.max_step));
        end
        if (got.mean_step !== want.mean_step) begin
            report_mismatch("mean_step", int'(got.mean_step), int'(want.mean_step));
        end
        if (got.fill_count !== want.fill_count) begin
            report_mismatch("fill_count", int'(got.fill_count), int'(want.fill_count));
        end
    endtask

    // Sample results on the accepting edge
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            check_result(out_item);
        end
    end

    // Offer one item, hold it until taken, then predict and maybe idle
    task automatic send_item(input t_in_item item, input bit has_want,
                             input t_out_item want);
        t_out_item predicted;
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
        predicted = judge_and_record(item);
        verdict_queue.push_back(has_want ? want : predicted);
        item_count++;
        if (item.kind == KIND_CLEAR) begin
            clear_count++;
        end
        if (!predicted.plausible) begin
            flagged_count++;
        end
        if (!quiet_tail && $urandom_range(0, 99) < in_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Write the limit once the block has drained
    task automatic set_max_change(input int value);
        in_valid <= 1'b0;
        while (verdict_queue.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CHG_W'(value);
        @(posedge clk);
        cfg_we           <= 1'b0;
        model_max_change = value;
    endtask

    // Stall the output side in random bursts, none in the tail
    initial begin : out_stall_gen
        int burst;
        forever begin
            if (quiet_tail) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                if ($urandom_range(0, 31) == 0) begin
                    out_stall_pct = $urandom_range(0, 2) * 35;
                end
                burst     = $urandom_range(1, 16);
                out_stall <= ($urandom_range(0, 99) < out_stall_pct);
                repeat (burst) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        t_row      rows [$];
        t_in_item  item;
        t_out_item no_want;
        int        phase_change [RANDOM_PHASES];
        int        walk;
        int        span;
        int        step;
        int        pick;
        no_want      = '0;
        phase_change = '{0, 1023, 1000, 1, -1, 50, -1};

        // Directed table: boundaries of range and limit, clears, every limit extreme
        rows.push_back(dir_row(ROW_SAMPLE, 0, 1, 0, 0, 1));       // empty history accepts
        rows.push_back(dir_row(ROW_SAMPLE, 50, 1, 50, 50, 2));    // jump exactly at limit
        rows.push_back(dir_row(ROW_SAMPLE, 101));                 // jump one past limit
        rows.push_back(dir_row(ROW_SAMPLE, 1001));                // just out of range
        rows.push_back(dir_row(ROW_SAMPLE, 2047));                // top of the field
        rows.push_back(dir_row(ROW_CLEAR, 2047, 1, 0, 0, 8));     // fill above range
        rows.push_back(dir_row(ROW_SAMPLE, 2047, 0, 0, 0, 8));    // out of range, stored
        rows.push_back(dir_row(ROW_CLEAR, 0, 1, 0, 0, 8));
        rows.push_back(dir_row(ROW_SAMPLE, 1000));                // full-scale jump
        rows.push_back(dir_row(ROW_CFG, 1000));
        rows.push_back(dir_row(ROW_CLEAR, 0));
        rows.push_back(dir_row(ROW_SAMPLE, 1000));
        rows.push_back(dir_row(ROW_SAMPLE, 1001));
        rows.push_back(dir_row(ROW_CFG, 0));
        rows.push_back(dir_row(ROW_CLEAR, 500));
        rows.push_back(dir_row(ROW_SAMPLE, 500));                 // zero limit, no change
        rows.push_back(dir_row(ROW_SAMPLE, 501));
        rows.push_back(dir_row(ROW_CFG, 1023));                   // limit above range
        rows.push_back(dir_row(ROW_CLEAR, 0));
        rows.push_back(dir_row(ROW_SAMPLE, 1000));
        rows.push_back(dir_row(ROW_SAMPLE, 0));
        rows.push_back(dir_row(ROW_CFG, 50));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (rows[r]) begin
            if (rows[r].op == ROW_CFG) begin
                set_max_change(rows[r].value);
            end else begin
                item.kind         = (rows[r].op == ROW_CLEAR) ? KIND_CLEAR : KIND_SAMPLE;
                item.sample_value = VAL_W'(rows[r].value);
                send_item(item, rows[r].has_want, rows[r].want);
            end
        end

        // Random phases: mostly slow drifts around a walking value, some clears and noise
        walk = 500;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_max_change(phase_change[p] < 0 ? $urandom_range(0, 1023) : phase_change[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == RANDOM_PHASES - 1 && i >= PHASE_ITEMS - QUIET_ITEMS) begin
                    quiet_tail = 1'b1;
                end
                if (i % 64 == 0) begin
                    in_gap_pct = $urandom_range(0, 2) * 30;
                end
                pick = $urandom_range(0, 99);
                if (pick < 7) begin
                    item.kind         = KIND_CLEAR;
                    item.sample_value = VAL_W'($urandom_range(0, 2047));
                    if (int'(item.sample_value) <= SOC_MAX) begin
                        walk = int'(item.sample_value);
                    end
                end else if (pick < 20) begin
                    item.kind         = KIND_SAMPLE;
                    item.sample_value = VAL_W'($urandom_range(0, 2047));
                end else begin
                    span = (model_max_change > SOC_MAX) ? SOC_MAX : model_max_change;
                    pick = $urandom_range(0, 99);
                    if (pick < 65) begin
                        step = $urandom_range(0, span / 8);
                    end else if (pick < 85) begin
                        step = $urandom_range(0, span);
                    end else if (pick < 92) begin
                        step = span;
                    end else begin
                        step = span + 1;
                    end
                    walk = $urandom_range(0, 1) ? walk + step : walk - step;
                    if (walk < 0) begin
                        walk = 0;
                    end
                    if (walk > SOC_MAX) begin
                        walk = SOC_MAX;
                    end
                    item.kind         = KIND_SAMPLE;
                    item.sample_value = VAL_W'(walk);
                end
                send_item(item, 1'b0, no_want);
            end
        end

        // Drain and let the block settle
        in_valid <= 1'b0;
        while (verdict_queue.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d items (%0d clears, %0d judged implausible), %0d results checked",
                 item_count, clear_count, flagged_count, result_count);
        $display("Limits covered: 0, 1, 50, 1000, 1023 and random values; mismatches: %0d",
                 error_count);
        if (error_count == 0) begin
            $display("sample_history_plausibility_check_tb passed");
        end else begin
            $display("sample_history_plausibility_check_tb failed");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("sample_history_plausibility_check_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/shpc_pkg.sv
hdl/shpc_ram.sv
hdl/shpc_datapath.sv
hdl/shpc_ctrl.sv
hdl/sample_history_plausibility_check.sv
hdl/shpc_checker.sv
bench/sample_history_plausibility_check_tb.sv
